@@ src/tcpo_pkg.sv @@
// Package for the TCP option parser: option codes, limits, phase enum,
// result beat and queue write types. No dependencies.
package tcpo_pkg;

   localparam int SACK_BLOCKS_MAX  = 4;
   localparam int MAX_OPTION_BYTES = 40;
   localparam int RSP_DEPTH        = 4;
   localparam int RSP_PTR_W        = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W        = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] KIND_END     = 8'd0;
   localparam logic [7:0] KIND_NOP     = 8'd1;
   localparam logic [7:0] KIND_MSS     = 8'd2;
   localparam logic [7:0] KIND_WSCALE  = 8'd3;
   localparam logic [7:0] KIND_SACK_OK = 8'd4;
   localparam logic [7:0] KIND_SACK    = 8'd5;

   localparam logic [7:0] MSS_LEN          = 8'd4;
   localparam logic [7:0] WSCALE_LEN       = 8'd3;
   localparam logic [7:0] WSCALE_MAX       = 8'd14;
   localparam logic [7:0] SACK_MIN_LEN     = 8'd10;
   localparam logic [7:0] OPT_HDR_LEN      = 8'd2;
   localparam logic [5:0] POS_MAX          = 6'd63;

   localparam logic RESULT_BLOCK   = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      PH_KIND = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2,
      PH_STOP = 2'd3
   } phase_type;

   typedef struct packed {
      logic        result_kind;
      logic        last_of_run;
      logic [15:0] mss_value;
      logic        has_mss;
      logic [3:0]  window_scale;
      logic        has_window_scale;
      logic        sack_allowed;
      logic [2:0]  sack_blocks;
      logic [1:0]  block_index;
      logic [31:0] block_left;
      logic [31:0] block_right;
   } rsp_item_type;

   typedef struct packed {
      logic         blk_valid;
      logic         sum_valid;
      rsp_item_type blk;
      rsp_item_type sum;
   } push_type;

endpackage

@@ src/tcpo_req_if.sv @@
// Input channel: one option byte per beat.
// Depends on nothing.
interface tcpo_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [5:0] total_len;
   logic       last_byte;

   modport source (output valid, data_byte, total_len, last_byte, input ready);
   modport sink   (input valid, data_byte, total_len, last_byte, output ready);
endinterface

@@ src/tcpo_rsp_if.sv @@
// Result channel: SACK block or summary per beat.
// Depends on nothing.
interface tcpo_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic        last_of_run;
   logic [15:0] mss_value;
   logic        has_mss;
   logic [3:0]  window_scale;
   logic        has_window_scale;
   logic        sack_allowed;
   logic [2:0]  sack_blocks;
   logic [1:0]  block_index;
   logic [31:0] block_left;
   logic [31:0] block_right;

   modport source (output valid, result_kind, last_of_run, mss_value, has_mss,
                   window_scale, has_window_scale, sack_allowed, sack_blocks,
                   block_index, block_left, block_right, input ready);
   modport sink   (input valid, result_kind, last_of_run, mss_value, has_mss,
                   window_scale, has_window_scale, sack_allowed, sack_blocks,
                   block_index, block_left, block_right, output ready);
endinterface

@@ src/tcpo_parse.sv @@
// Option parser state and per-beat decode; writes up to two results.
// Depends on tcpo_pkg.
module tcpo_parse
   import tcpo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic [5:0] total_len,
   input  logic       last_byte,
   output push_type   push
);

   logic [5:0]  pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  optlen_ff, optlen_in;
   logic [7:0]  off_ff, off_in;
   logic [63:0] shift_ff, shift_in;
   logic [15:0] mss_ff, mss_in;
   logic        has_mss_ff, has_mss_in;
   logic [3:0]  scale_ff, scale_in;
   logic        has_scale_ff, has_scale_in;
   logic        sack_ok_ff, sack_ok_in;
   logic [2:0]  count_ff, count_in;
   logic [2:0]  examined_ff, examined_in;
   logic [2:0]  limit_ff, limit_in;

   logic [7:0]  eff, pos8, off_next;
   logic [63:0] new_shift;
   logic [31:0] diff;
   logic [4:0]  blocks;
   logic        empty, do_sum;

   assign empty     = (total_len == 6'd0);
   assign do_sum    = accept && (empty || last_byte);
   assign pos8      = {2'b00, pos_ff};
   assign eff       = ({2'b00, total_len} > 8'(MAX_OPTION_BYTES)) ?
                      8'(MAX_OPTION_BYTES) : {2'b00, total_len};
   assign new_shift = {shift_ff[55:0], data_byte};
   assign diff      = new_shift[31:0] - new_shift[63:32];
   assign blocks    = 5'((data_byte - OPT_HDR_LEN) >> 3);
   assign off_next  = off_ff + 8'd1;

   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      optlen_in    = optlen_ff;
      off_in       = off_ff;
      shift_in     = shift_ff;
      mss_in       = mss_ff;
      has_mss_in   = has_mss_ff;
      scale_in     = scale_ff;
      has_scale_in = has_scale_ff;
      sack_ok_in   = sack_ok_ff;
      count_in     = count_ff;
      examined_in  = examined_ff;
      limit_in     = limit_ff;
      push         = '0;

      if (accept && !empty) begin
         if (pos8 < eff) begin
            unique case (phase_ff)
               PH_KIND: begin
                  if (data_byte == KIND_END) begin
                     phase_in = PH_STOP;
                  end else if (data_byte != KIND_NOP) begin
                     if (pos8 + 8'd1 >= eff) begin
                        phase_in = PH_STOP;
                     end else begin
                        kind_in  = data_byte;
                        phase_in = PH_LEN;
                     end
                  end
               end
               PH_LEN: begin
                  if (data_byte < OPT_HDR_LEN ||
                      ({2'b00, pos8} - 10'd1 + {2'b00, data_byte}) > {2'b00, eff}) begin
                     phase_in = PH_STOP;
                  end else begin
                     optlen_in   = data_byte;
                     off_in      = OPT_HDR_LEN;
                     shift_in    = '0;
                     examined_in = '0;
                     limit_in    = '0;
                     if (kind_ff == KIND_SACK && data_byte >= SACK_MIN_LEN &&
                         (data_byte - OPT_HDR_LEN) % 8 == 8'd0) begin
                        limit_in = (blocks > 5'(SACK_BLOCKS_MAX)) ?
                                   3'(SACK_BLOCKS_MAX) : blocks[2:0];
                     end
                     if (data_byte == OPT_HDR_LEN) begin
                        if (kind_ff == KIND_SACK_OK) begin
                           sack_ok_in = 1'b1;
                        end
                        phase_in = PH_KIND;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end
               PH_BODY: begin
                  shift_in = new_shift;
                  if (kind_ff == KIND_MSS && optlen_ff == MSS_LEN && off_ff == 8'd3) begin
                     mss_in     = new_shift[15:0];
                     has_mss_in = 1'b1;
                  end else if (kind_ff == KIND_WSCALE && optlen_ff == WSCALE_LEN &&
                               off_ff == 8'd2) begin
                     if (data_byte <= WSCALE_MAX) begin
                        scale_in     = data_byte[3:0];
                        has_scale_in = 1'b1;
                     end
                  end else if (kind_ff == KIND_SACK && limit_ff != 3'd0 &&
                               (off_ff - OPT_HDR_LEN) % 8 == 8'd7) begin
                     if (examined_ff < limit_ff) begin
                        examined_in = examined_ff + 3'd1;
                        if (diff != 32'd0 && !diff[31] &&
                            count_ff < 3'(SACK_BLOCKS_MAX)) begin
                           count_in                    = count_ff + 3'd1;
                           push.blk_valid              = 1'b1;
                           push.blk.result_kind        = RESULT_BLOCK;
                           push.blk.last_of_run        = RESULT_BLOCK;
                           push.blk.block_index        = count_ff[1:0];
                           push.blk.block_left         = new_shift[63:32];
                           push.blk.block_right        = new_shift[31:0];
                        end
                     end
                  end
                  off_in = off_next;
                  if (off_next >= optlen_ff) begin
                     phase_in = PH_KIND;
                  end
               end
               PH_STOP: begin
               end
            endcase
         end
         pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 6'd1;
      end

      push.blk.mss_value        = mss_in;
      push.blk.has_mss          = has_mss_in;
      push.blk.window_scale     = scale_in;
      push.blk.has_window_scale = has_scale_in;
      push.blk.sack_allowed     = sack_ok_in;
      push.blk.sack_blocks      = count_in;

      push.sum_valid = do_sum;
      push.sum.result_kind = RESULT_SUMMARY;
      push.sum.last_of_run = RESULT_SUMMARY;
      if (!empty) begin
         push.sum.mss_value        = mss_in;
         push.sum.has_mss          = has_mss_in;
         push.sum.window_scale     = scale_in;
         push.sum.has_window_scale = has_scale_in;
         push.sum.sack_allowed     = sack_ok_in;
         push.sum.sack_blocks      = count_in;
      end

      if (do_sum) begin
         pos_in       = '0;
         phase_in     = PH_KIND;
         kind_in      = '0;
         optlen_in    = '0;
         off_in       = '0;
         shift_in     = '0;
         mss_in       = '0;
         has_mss_in   = 1'b0;
         scale_in     = '0;
         has_scale_in = 1'b0;
         sack_ok_in   = 1'b0;
         count_in     = '0;
         examined_in  = '0;
         limit_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= PH_KIND;
         kind_ff      <= '0;
         optlen_ff    <= '0;
         off_ff       <= '0;
         shift_ff     <= '0;
         mss_ff       <= '0;
         has_mss_ff   <= 1'b0;
         scale_ff     <= '0;
         has_scale_ff <= 1'b0;
         sack_ok_ff   <= 1'b0;
         count_ff     <= '0;
         examined_ff  <= '0;
         limit_ff     <= '0;
      end else begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         optlen_ff    <= optlen_in;
         off_ff       <= off_in;
         shift_ff     <= shift_in;
         mss_ff       <= mss_in;
         has_mss_ff   <= has_mss_in;
         scale_ff     <= scale_in;
         has_scale_ff <= has_scale_in;
         sack_ok_ff   <= sack_ok_in;
         count_ff     <= count_in;
         examined_ff  <= examined_in;
         limit_ff     <= limit_in;
      end
   end

`ifndef SYNTH
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(SACK_BLOCKS_MAX)) else $error("sack count over cap");
   a_examined: assert property (@(posedge clock) disable iff (reset)
      examined_ff <= limit_ff) else $error("examined past block limit");
   a_blk_body: assert property (@(posedge clock) disable iff (reset)
      push.blk_valid |-> (phase_ff == PH_BODY && kind_ff == KIND_SACK))
      else $error("block beat outside SACK body");
   a_empty_clr: assert property (@(posedge clock) disable iff (reset)
      (accept && empty) |=> (pos_ff == 6'd0 && count_ff == 3'd0 && !has_mss_ff))
      else $error("empty area did not clear state");
`endif

endmodule

@@ src/tcpo_rsp_fifo.sv @@
// Result queue: takes up to two beats per cycle, sends one.
// Depends on tcpo_pkg.
module tcpo_rsp_fifo
   import tcpo_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop,
   output logic         space_ok,
   output logic         head_valid,
   output rsp_item_type head
);

   rsp_item_type         mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_CNT_W-1:0] push_cnt;
   logic [RSP_PTR_W-1:0] sum_addr;

   assign push_cnt   = RSP_CNT_W'(push.blk_valid) + RSP_CNT_W'(push.sum_valid);
   assign sum_addr   = wr_ptr_ff + RSP_PTR_W'(push.blk_valid);
   assign space_ok   = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = mem[rd_ptr_ff];
   assign wr_ptr_in  = wr_ptr_ff + RSP_PTR_W'(push_cnt);
   assign rd_ptr_in  = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in   = count_ff + push_cnt - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.blk_valid) begin
         mem[wr_ptr_ff] <= push.blk;
      end
      if (push.sum_valid) begin
         mem[sum_addr] <= push.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH)) else $error("result queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != '0) |-> space_ok) else $error("write without room");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      RSP_PTR_W'(wr_ptr_ff - rd_ptr_ff) == RSP_PTR_W'(count_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

@@ src/tcp_option_parser.sv @@
// TCP option parser top: parser state feeding a four-beat result queue.
// A result beat is offered the cycle after its byte is accepted, behind any
// beats queued ahead of it.
// Throughput: one byte per cycle; a byte may produce a SACK block and the
// summary, and bytes are held off while the queue has under two free entries.
// Reset (synchronous) clears the parser state and empties the queue.
module tcp_option_parser
   import tcpo_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tcpo_req_if.sink   req_ch,
   tcpo_rsp_if.source rsp_ch
);

   push_type     push;
   rsp_item_type head;
   logic         space_ok;
   logic         head_valid;
   logic         accept;

   assign req_ch.ready = space_ok;
   assign accept       = req_ch.valid && space_ok;

   tcpo_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_ch.data_byte),
      .total_len (req_ch.total_len),
      .last_byte (req_ch.last_byte),
      .push      (push)
   );

   tcpo_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (head_valid && rsp_ch.ready),
      .space_ok   (space_ok),
      .head_valid (head_valid),
      .head       (head)
   );

   assign rsp_ch.valid            = head_valid;
   assign rsp_ch.result_kind      = head.result_kind;
   assign rsp_ch.last_of_run      = head.last_of_run;
   assign rsp_ch.mss_value        = head.mss_value;
   assign rsp_ch.has_mss          = head.has_mss;
   assign rsp_ch.window_scale     = head.window_scale;
   assign rsp_ch.has_window_scale = head.has_window_scale;
   assign rsp_ch.sack_allowed     = head.sack_allowed;
   assign rsp_ch.sack_blocks      = head.sack_blocks;
   assign rsp_ch.block_index      = head.block_index;
   assign rsp_ch.block_left       = head.block_left;
   assign rsp_ch.block_right      = head.block_right;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for tcp_option_parser: directed option areas, then random ones.
// Built-in parser predictor, bursty byte source, patterned result stall.
// Depends on tcpo_pkg, tcpo_req_if, tcpo_rsp_if and the parser RTL.
module tb;
   import tcpo_pkg::*;

   localparam int RANDOM_ITEMS = 750;

   localparam rsp_item_type SUM_ZERO =
      '{RESULT_SUMMARY, 1'b1, 16'h0000, 1'b0, 4'h0, 1'b0, 1'b0, 3'd0, 2'd0, 32'h0, 32'h0};
   localparam rsp_item_type SUM_FULL =
      '{RESULT_SUMMARY, 1'b1, 16'hFFFF, 1'b1, 4'hE, 1'b1, 1'b1, 3'd0, 2'd0, 32'h0, 32'h0};
   localparam rsp_item_type SUM_ONE_SACK =
      '{RESULT_SUMMARY, 1'b1, 16'h0000, 1'b0, 4'h0, 1'b0, 1'b0, 3'd1, 2'd0, 32'h0, 32'h0};

   typedef struct packed {
      logic [7:0]   data_byte;
      logic [5:0]   total_len;
      logic         last_byte;
      logic         typed;
      rsp_item_type sum;
   } stim_row_type;

   // empty area, full-feature area, wrapping sack block, bad length byte
   stim_row_type dir_rows [25] = '{
      '{8'hFF, 6'd0,  1'b0, 1'b1, SUM_ZERO},
      '{8'h02, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'h04, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'hFF, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'hFF, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'h03, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'h03, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'h0E, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'h04, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'h02, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'h01, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'h00, 6'd12, 1'b0, 1'b0, SUM_ZERO},
      '{8'hA5, 6'd12, 1'b1, 1'b1, SUM_FULL},
      '{8'h05, 6'd10, 1'b0, 1'b0, SUM_ZERO},
      '{8'h0A, 6'd10, 1'b0, 1'b0, SUM_ZERO},
      '{8'hFF, 6'd10, 1'b0, 1'b0, SUM_ZERO},
      '{8'hFF, 6'd10, 1'b0, 1'b0, SUM_ZERO},
      '{8'hFF, 6'd10, 1'b0, 1'b0, SUM_ZERO},
      '{8'hFF, 6'd10, 1'b0, 1'b0, SUM_ZERO},
      '{8'h00, 6'd10, 1'b0, 1'b0, SUM_ZERO},
      '{8'h00, 6'd10, 1'b0, 1'b0, SUM_ZERO},
      '{8'h00, 6'd10, 1'b0, 1'b0, SUM_ZERO},
      '{8'h00, 6'd10, 1'b1, 1'b1, SUM_ONE_SACK},
      '{8'h09, 6'd2,  1'b0, 1'b0, SUM_ZERO},
      '{8'h01, 6'd2,  1'b1, 1'b1, SUM_ZERO}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcpo_req_if req_ch ();
   tcpo_rsp_if rsp_ch ();

   tcp_option_parser u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [5:0]   pos_q;
   phase_type    phase_q;
   logic [7:0]   kind_q;
   logic [7:0]   optlen_q;
   logic [7:0]   offset_q;
   logic [63:0]  shift_q;
   logic [15:0]  mss_q;
   logic         mss_ok_q;
   logic [3:0]   wscale_q;
   logic         wscale_ok_q;
   logic         sack_ok_q;
   logic [2:0]   sack_cnt_q;
   logic [2:0]   examined_q;
   logic [2:0]   limit_q;

   rsp_item_type pending_results [$];
   logic [7:0]   area_bytes [$];

   logic         row_typed_q = 1'b0;
   rsp_item_type row_sum_q = SUM_ZERO;

   logic [15:0]  ready_pat = '1;
   logic [6:0]   ready_phase = '0;

   int err_count = 0;
   int items_sent = 0;
   int beats_checked = 0;
   int blocks_seen = 0;
   int summaries_seen = 0;
   int burst_left = 0;

   function automatic void clear_parser();
      pos_q       = '0;
      phase_q     = PH_KIND;
      kind_q      = '0;
      optlen_q    = '0;
      offset_q    = '0;
      shift_q     = '0;
      mss_q       = '0;
      mss_ok_q    = 1'b0;
      wscale_q    = '0;
      wscale_ok_q = 1'b0;
      sack_ok_q   = 1'b0;
      sack_cnt_q  = '0;
      examined_q  = '0;
      limit_q     = '0;
   endfunction

   function automatic void push_result(logic kind, logic [1:0] idx, logic [31:0] lo,
                                       logic [31:0] hi);
      rsp_item_type t;
      t.result_kind      = kind;
      t.last_of_run      = kind;
      t.mss_value        = mss_q;
      t.has_mss          = mss_ok_q;
      t.window_scale     = wscale_q;
      t.has_window_scale = wscale_ok_q;
      t.sack_allowed     = sack_ok_q;
      t.sack_blocks      = sack_cnt_q;
      t.block_index      = idx;
      t.block_left       = lo;
      t.block_right      = hi;
      pending_results.push_back(t);
   endfunction

   function automatic void option_body(logic [7:0] b);
      logic [7:0]  off;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] span;
      logic [1:0]  idx;
      off = offset_q;
      shift_q = {shift_q[55:0], b};
      if (kind_q == KIND_MSS && optlen_q == MSS_LEN && off == 8'd3) begin
         mss_q = shift_q[15:0];
         mss_ok_q = 1'b1;
      end else if (kind_q == KIND_WSCALE && optlen_q == WSCALE_LEN && off == 8'd2) begin
         if (b <= WSCALE_MAX) begin
            wscale_q = b[3:0];
            wscale_ok_q = 1'b1;
         end
      end else if (kind_q == KIND_SACK && limit_q != 3'd0
                   && ((off - OPT_HDR_LEN) & 8'd7) == 8'd7) begin
         // last byte of an 8-byte block
         if (examined_q < limit_q) begin
            lo = shift_q[63:32];
            hi = shift_q[31:0];
            span = hi - lo;
            examined_q = examined_q + 3'd1;
            if (span != 32'd0 && !span[31] && sack_cnt_q < 3'(SACK_BLOCKS_MAX)) begin
               idx = sack_cnt_q[1:0];
               sack_cnt_q = sack_cnt_q + 3'd1;
               push_result(RESULT_BLOCK, idx, lo, hi);
            end
         end
      end
      offset_q = off + 8'd1;
      if (offset_q >= optlen_q) phase_q = PH_KIND;
   endfunction

   function automatic void option_byte(logic [7:0] b, int pos, int eff);
      int nblk;
      case (phase_q)
         PH_KIND: begin
            if (b == KIND_END) begin
               phase_q = PH_STOP;
            end else if (b != KIND_NOP) begin
               if (pos + 1 >= eff) begin
                  phase_q = PH_STOP;
               end else begin
                  kind_q = b;
                  phase_q = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            if (b < OPT_HDR_LEN || pos - 1 + int'(b) > eff) begin
               phase_q = PH_STOP;
            end else begin
               optlen_q = b;
               offset_q = OPT_HDR_LEN;
               shift_q = '0;
               examined_q = '0;
               limit_q = '0;
               if (kind_q == KIND_SACK && b >= SACK_MIN_LEN
                   && ((b - OPT_HDR_LEN) & 8'd7) == 8'd0) begin
                  nblk = int'(b - OPT_HDR_LEN) >> 3;
                  limit_q = 3'(nblk > SACK_BLOCKS_MAX ? SACK_BLOCKS_MAX : nblk);
               end
               if (b == OPT_HDR_LEN) begin
                  if (kind_q == KIND_SACK_OK) sack_ok_q = 1'b1;
                  phase_q = PH_KIND;
               end else begin
                  phase_q = PH_BODY;
               end
            end
         end
         PH_BODY: option_body(b);
         default: ;
      endcase
   endfunction

   function automatic void predict_beat(logic [7:0] b, logic [5:0] len, logic lst);
      int eff;
      if (len == 6'd0) begin
         clear_parser();
         push_result(RESULT_SUMMARY, 2'd0, 32'h0, 32'h0);
         return;
      end
      eff = int'(len) > MAX_OPTION_BYTES ? MAX_OPTION_BYTES : int'(len);
      if (int'(pos_q) < eff) option_byte(b, int'(pos_q), eff);
      if (pos_q < POS_MAX) pos_q = pos_q + 6'd1;
      if (lst) begin
         push_result(RESULT_SUMMARY, 2'd0, 32'h0, 32'h0);
         clear_parser();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      // keep the log short on a broken build
      if (err_count <= 100)
         $display("tb: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   task automatic check_result();
      rsp_item_type got;
      rsp_item_type want;
      got.result_kind      = rsp_ch.result_kind;
      got.last_of_run      = rsp_ch.last_of_run;
      got.mss_value        = rsp_ch.mss_value;
      got.has_mss          = rsp_ch.has_mss;
      got.window_scale     = rsp_ch.window_scale;
      got.has_window_scale = rsp_ch.has_window_scale;
      got.sack_allowed     = rsp_ch.sack_allowed;
      got.sack_blocks      = rsp_ch.sack_blocks;
      got.block_index      = rsp_ch.block_index;
      got.block_left       = rsp_ch.block_left;
      got.block_right      = rsp_ch.block_right;
      beats_checked++;
      if (got.result_kind == RESULT_SUMMARY) summaries_seen++;
      else blocks_seen++;
      if (pending_results.size() == 0) begin
         report_mismatch("beat with nothing pending", 32'(got.result_kind), 32'h0);
      end else begin
         want = pending_results.pop_front();
         check_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
         check_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
         check_field("mss_value", 32'(got.mss_value), 32'(want.mss_value));
         check_field("has_mss", 32'(got.has_mss), 32'(want.has_mss));
         check_field("window_scale", 32'(got.window_scale), 32'(want.window_scale));
         check_field("has_window_scale", 32'(got.has_window_scale),
                     32'(want.has_window_scale));
         check_field("sack_allowed", 32'(got.sack_allowed), 32'(want.sack_allowed));
         check_field("sack_blocks", 32'(got.sack_blocks), 32'(want.sack_blocks));
         check_field("block_index", 32'(got.block_index), 32'(want.block_index));
         check_field("block_left", got.block_left, want.block_left);
         check_field("block_right", got.block_right, want.block_right);
      end
   endtask

   // predict accepted bytes first, then check results leaving this edge
   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_beat(req_ch.data_byte, req_ch.total_len, req_ch.last_byte);
            if (row_typed_q) pending_results[pending_results.size() - 1] = row_sum_q;
         end
         if (rsp_ch.valid && rsp_ch.ready) check_result();
      end
   end

   // result stall: rotating pattern, reloaded when the phase counter wraps, sometimes all-ready
   always @(posedge clock) begin
      ready_phase <= ready_phase + 7'd1;
      if (ready_phase == 7'd0)
         ready_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
      else
         ready_pat <= {ready_pat[0], ready_pat[15:1]};
      rsp_ch.ready <= ready_pat[0];
   end

   task automatic send_beat(input logic [7:0] b, input logic [5:0] len, input logic lst,
                            input logic typed, input rsp_item_type sum);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.total_len <= len;
      req_ch.last_byte <= lst;
      row_typed_q      <= typed;
      row_sum_q        <= sum;
      items_sent++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_area(input logic [5:0] len, input logic close, input logic wobble);
      logic [5:0] l;
      for (int i = 0; i < area_bytes.size(); i++) begin
         l = (wobble && $urandom_range(0, 3) == 0) ? 6'($urandom_range(1, 63)) : len;
         send_beat(area_bytes[i], l, close && i == area_bytes.size() - 1, 1'b0, SUM_ZERO);
      end
   endtask

   task automatic push_word(input logic [31:0] w);
      for (int s = 24; s >= 0; s -= 8) area_bytes.push_back(8'(w >> s));
   endtask

   task automatic build_options(input int room);
      int          left_bytes;
      int          pick;
      int          n;
      int          olen;
      logic [31:0] sack_lo;
      logic [31:0] sack_hi;
      area_bytes.delete();
      while (area_bytes.size() < room) begin
         left_bytes = room - area_bytes.size();
         pick = $urandom_range(0, 11);
         if (pick == 1 && left_bytes >= 4) begin
            area_bytes.push_back(KIND_MSS);
            area_bytes.push_back(MSS_LEN);
            area_bytes.push_back(8'($urandom));
            area_bytes.push_back(8'($urandom));
         end else if (pick == 2 && left_bytes >= 3) begin
            area_bytes.push_back(KIND_WSCALE);
            area_bytes.push_back(WSCALE_LEN);
            area_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 15)));
         end else if (pick == 3 && left_bytes >= 2) begin
            area_bytes.push_back(KIND_SACK_OK);
            area_bytes.push_back(OPT_HDR_LEN);
         end else if (pick >= 4 && pick <= 6 && left_bytes >= 10) begin
            n = (left_bytes - 2) / 8;
            n = $urandom_range(1, n > SACK_BLOCKS_MAX ? SACK_BLOCKS_MAX : n);
            area_bytes.push_back(KIND_SACK);
            area_bytes.push_back(8'(2 + 8 * n));
            repeat (n) begin
               sack_lo = $urandom;
               case ($urandom_range(0, 5))
                  0:       sack_hi = sack_lo;
                  1:       sack_hi = sack_lo + 32'h8000_0000;
                  2:       sack_hi = sack_lo + 32'h7FFF_FFFF;
                  3:       sack_hi = sack_lo - 32'($urandom_range(1, 100));
                  default: sack_hi = sack_lo + 32'($urandom_range(1, 100000));
               endcase
               push_word(sack_lo);
               push_word(sack_hi);
            end
         end else if (pick == 7 && left_bytes >= 2) begin
            olen = $urandom_range(2, left_bytes > 8 ? 8 : left_bytes);
            area_bytes.push_back(8'($urandom_range(2, 255)));
            area_bytes.push_back(8'(olen));
            repeat (olen - 2) area_bytes.push_back(8'($urandom));
         end else if (pick == 8 && $urandom_range(0, 3) == 0) begin
            area_bytes.push_back(KIND_END);
            while (area_bytes.size() < room) area_bytes.push_back(8'($urandom));
         end else if (pick == 9 && left_bytes >= 2 && $urandom_range(0, 3) == 0) begin
            // length byte too short or running past the area
            area_bytes.push_back(8'($urandom_range(2, 255)));
            area_bytes.push_back(($urandom_range(0, 1) == 0)
                                 ? 8'($urandom_range(0, 1))
                                 : 8'(left_bytes + $urandom_range(1, 10)));
         end else begin
            area_bytes.push_back(KIND_NOP);
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   initial begin
      int pick;
      int room;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.total_len <= '0;
      req_ch.last_byte <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_beat(dir_rows[i].data_byte, dir_rows[i].total_len, dir_rows[i].last_byte,
                   dir_rows[i].typed, dir_rows[i].sum);

      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         room = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 16) : $urandom_range(17, 40);
         if (pick < 70) begin
            build_options(room);
            send_area(6'(room), 1'b1, 1'b0);
         end else if (pick < 76) begin
            // no last byte: state carries into the next area
            build_options(room);
            send_area(6'(room), 1'b0, 1'b0);
         end else if (pick < 82) begin
            build_options(room);
            send_area(6'(room), 1'b1, 1'b1);
         end else if (pick < 88) begin
            area_bytes.delete();
            repeat (room)
               area_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(0, 12)));
            send_area(6'(room), 1'b1, 1'b0);
         end else if (pick < 92) begin
            build_options(room);
            repeat ($urandom_range(1, 6)) area_bytes.push_back(8'($urandom));
            send_area(6'(room), 1'b1, 1'b0);
         end else if (pick < 95) begin
            build_options(MAX_OPTION_BYTES);
            send_area(6'($urandom_range(41, 63)), 1'b1, 1'b0);
         end else if (pick < 99) begin
            send_beat(8'($urandom), 6'd0, 1'($urandom_range(0, 1)), 1'b0, SUM_ZERO);
         end else begin
            // long run: position counter saturates
            build_options(MAX_OPTION_BYTES);
            repeat (30) area_bytes.push_back(8'($urandom));
            send_area(6'(MAX_OPTION_BYTES), 1'b1, 1'b0);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("tb: %0d option bytes sent, %0d result beats checked", items_sent,
               beats_checked);
      $display("tb: %0d sack blocks and %0d summaries seen", blocks_seen, summaries_seen);
      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
